// File: rtl/wcb_pkg.sv
// shared types, constants and the control store for the weld current boost block
`timescale 1ns / 1ps

package wcb_pkg;

    // field widths
    localparam int TIME_W   = 32;
    localparam int SAMPLE_W = 12;
    localparam int THR_W    = 12;
    localparam int CMP_W    = (SAMPLE_W > THR_W) ? SAMPLE_W : THR_W;
    localparam int PCT_W    = 7;
    localparam int HSMS_W   = 16;
    localparam int AMP_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // shared multiplier and accumulator width
    localparam int MUL_W  = 24;
    localparam int PROD_W = 2 * MUL_W;

    // current limits and duty span
    localparam logic [AMP_W-1:0] AMP_MIN  = 8'd10;
    localparam logic [AMP_W-1:0] AMP_MAX  = 8'd220;
    localparam logic [AMP_W-1:0] PCT_BASE = 8'd100;

    // reciprocal of 10000: exact floor for products below 2^24
    localparam logic [MUL_W-1:0] RECIP_10K = 24'd13743896;
    localparam int               SHIFT_10K = 37;
    // reciprocal of 210: exact floor for products below 2^16
    localparam logic [MUL_W-1:0] RECIP_210 = 24'd79892;
    localparam int               SHIFT_210 = 24;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIG_MODE        = 3'd0,
        CFG_HOT_START_PCT   = 3'd1,
        CFG_ARC_FORCE_PCT   = 3'd2,
        CFG_STICK_THRESHOLD = 3'd3,
        CFG_WELD_THRESHOLD  = 3'd4,
        CFG_HOT_START_MS    = 3'd5,
        CFG_DUTY_FULL_SCALE = 3'd6
    } cfg_index_t;

    // arc classification
    typedef enum logic [1:0] {
        ARC_IDLE  = 2'd0,
        ARC_WELD  = 2'd1,
        ARC_STICK = 2'd2
    } arc_state_t;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NONE     = 3'd0,
        OP_MUL_HS   = 3'd1,
        OP_MUL_AF   = 3'd2,
        OP_MUL_R10K = 3'd3,
        OP_MUL_FS   = 3'd4,
        OP_MUL_R210 = 3'd5
    } dp_op_t;

    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_FIRST = 3'd0;
    localparam logic [STEP_W-1:0] STEP_EMIT  = 3'd5;

    // one control word
    typedef struct packed {
        dp_op_t            op;
        logic              upd;
        logic              jmp_hot;
        logic [STEP_W-1:0] target;
        logic              emit;
    } ucode_t;

    localparam ucode_t UC_IDLE = '{op: OP_NONE, upd: 1'b0, jmp_hot: 1'b0,
                                   target: STEP_FIRST, emit: 1'b0};

    // sequencer status towards the datapath and the output stage
    typedef struct packed {
        logic              busy;
        logic              fire;
        logic [STEP_W-1:0] step;
        ucode_t            uc;
    } seq_out_t;

    // per tick arc information
    typedef struct packed {
        arc_state_t state;
        logic       boosted;
    } arc_info_t;

    typedef struct packed {
        logic [TIME_W-1:0]   now_ms;
        logic [SAMPLE_W-1:0] arc_sample;
        logic [AMP_W-1:0]    set_current;
        logic                overheat;
    } in_item_t;

    typedef struct packed {
        logic             pwm_on;
        logic [AMP_W-1:0] duty;
        logic             duty_written;
        logic [1:0]       arc_state;
        logic             boost_active;
    } out_item_t;

    // control store
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        w = UC_IDLE;
        case (step)
            3'd0:
            begin
                w.op      = OP_MUL_HS;
                w.upd     = 1'b1;
                w.jmp_hot = 1'b1;
                w.target  = STEP_EMIT;
            end
            3'd1: w.op = OP_MUL_AF;
            3'd2: w.op = OP_MUL_R10K;
            3'd3: w.op = OP_MUL_FS;
            3'd4: w.op = OP_MUL_R210;
            default: w.emit = 1'b1;
        endcase
        return w;
    endfunction

endpackage

// File: rtl/weld_current_boost_pwm.sv
// weld current controller top level: config registers, item and result stages
// a new tick is taken only while idle or as the result step hands its result on; the single
// shared multiplier is walked through five control store steps plus the result step, and
// overheat jumps from the first step straight to the result step
// reset: asynchronous active low, config to defaults, hot start armed, no result held
`timescale 1ns / 1ps

module weld_current_boost_pwm (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  wcb_pkg::in_item_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output wcb_pkg::out_item_t                  out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wcb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wcb_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import wcb_pkg::*;

    logic              tig_reg;
    logic [PCT_W-1:0]  hs_pct_reg, af_pct_reg;
    logic [THR_W-1:0]  stick_reg, weld_reg;
    logic [HSMS_W-1:0] hs_ms_reg;
    logic [AMP_W-1:0]  fs_reg;

    in_item_t  item_reg;
    out_item_t out_reg, out_next;
    logic      out_valid_reg, out_valid_next;

    seq_out_t         seq_st;
    arc_info_t        info;
    logic [MUL_W-1:0] acc;
    logic             in_xfer, out_free;

    // handshakes
    assign out_free  = ~out_valid_reg | ~out_stall;
    assign in_stall  = seq_st.busy & ~seq_st.fire;
    assign in_xfer   = in_valid & ~in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tig_reg    <= 1'b0;
            hs_pct_reg <= 7'd25;
            af_pct_reg <= 7'd20;
            stick_reg  <= 12'd1241;
            weld_reg   <= 12'd2358;
            hs_ms_reg  <= 16'd1000;
            fs_reg     <= 8'd210;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TIG_MODE:        tig_reg    <= cfg_data[0];
                CFG_HOT_START_PCT:   hs_pct_reg <= cfg_data[PCT_W-1:0];
                CFG_ARC_FORCE_PCT:   af_pct_reg <= cfg_data[PCT_W-1:0];
                CFG_STICK_THRESHOLD: stick_reg  <= cfg_data[THR_W-1:0];
                CFG_WELD_THRESHOLD:  weld_reg   <= cfg_data[THR_W-1:0];
                CFG_HOT_START_MS:    hs_ms_reg  <= cfg_data[HSMS_W-1:0];
                CFG_DUTY_FULL_SCALE: fs_reg     <= cfg_data[AMP_W-1:0];
                default: ;
            endcase
        end
    end

    // input item held for the whole tick
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            item_reg <= in_data;
    end

    wcb_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_xfer),
        .hot      (item_reg.overheat),
        .out_free (out_free),
        .sts      (seq_st)
    );

    wcb_arc u_arc (
        .clk             (clk),
        .rst_n           (rst_n),
        .upd             (seq_st.uc.upd),
        .tig_mode        (tig_reg),
        .stick_threshold (stick_reg),
        .weld_threshold  (weld_reg),
        .hot_start_ms    (hs_ms_reg),
        .arc_sample      (item_reg.arc_sample),
        .now_ms          (item_reg.now_ms),
        .info            (info)
    );

    wcb_dp u_dp (
        .clk               (clk),
        .op                (seq_st.uc.op),
        .set_current       (item_reg.set_current),
        .info              (info),
        .hot_start_percent (hs_pct_reg),
        .arc_force_percent (af_pct_reg),
        .duty_full_scale   (fs_reg),
        .acc               (acc)
    );

    // result assembly
    always_comb
    begin
        out_next.pwm_on       = ~item_reg.overheat;
        out_next.duty         = item_reg.overheat ? '0 : acc[AMP_W-1:0];
        out_next.duty_written = ~item_reg.overheat;
        out_next.arc_state    = 2'(info.state);
        out_next.boost_active = info.boosted;
        if (seq_st.fire)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg & out_stall;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (seq_st.fire)
            out_reg <= out_next;
    end

    // checks
    a_no_duty_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.duty_written |-> out_data.duty == '0)
        else $error("duty not zero while pwm stopped");

    a_duty_within_scale: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.duty_written |-> out_data.duty <= fs_reg)
        else $error("duty above full scale");

    a_start_at_first_step: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> seq_st.busy && seq_st.step == STEP_FIRST)
        else $error("sequencer did not start at first step");

    a_fire_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        seq_st.fire |=> out_valid)
        else $error("result transfer lost");

endmodule

// File: rtl/wcb_seq.sv
// step counter and control store walk for one tick
`timescale 1ns / 1ps

module wcb_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             hot,
    input  logic             out_free,
    output wcb_pkg::seq_out_t sts
);
    import wcb_pkg::*;

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    ucode_t            uc;

    assign uc = ucode_rom(step_reg);

    // status towards the rest of the block
    always_comb
    begin
        sts.busy = busy_reg;
        sts.fire = busy_reg & uc.emit & out_free;
        sts.step = step_reg;
        sts.uc   = busy_reg ? uc : UC_IDLE;
    end

    // next step, with the overheat jump
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_FIRST;
        end
        else if (busy_reg)
        begin
            if (uc.emit)
            begin
                if (out_free)
                begin
                    busy_next = 1'b0;
                end
            end
            else if (uc.jmp_hot && hot)
            begin
                step_next = uc.target;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= STEP_FIRST;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

endmodule

// File: rtl/wcb_arc.sv
// arc classification and hot start timing
`timescale 1ns / 1ps

module wcb_arc (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         upd,
    input  logic                         tig_mode,
    input  logic [wcb_pkg::THR_W-1:0]    stick_threshold,
    input  logic [wcb_pkg::THR_W-1:0]    weld_threshold,
    input  logic [wcb_pkg::HSMS_W-1:0]   hot_start_ms,
    input  logic [wcb_pkg::SAMPLE_W-1:0] arc_sample,
    input  logic [wcb_pkg::TIME_W-1:0]   now_ms,
    output wcb_pkg::arc_info_t           info
);
    import wcb_pkg::*;

    logic              armed_reg, armed_next;
    arc_state_t        prev_reg;
    logic [TIME_W-1:0] began_reg, began_next;
    logic              timing_reg, timing_next;
    logic              boost_reg;

    arc_state_t        st;
    logic              armed0, start, expire;
    logic [TIME_W-1:0] elapsed;

    // classify the sample
    always_comb
    begin
        if (tig_mode)
            st = ARC_IDLE;
        else if (CMP_W'(arc_sample) < CMP_W'(stick_threshold))
            st = ARC_STICK;
        else if (CMP_W'(arc_sample) < CMP_W'(weld_threshold))
            st = ARC_WELD;
        else
            st = ARC_IDLE;
    end

    // hot start arm, start and expiry
    always_comb
    begin
        armed0      = armed_reg & ~tig_mode;
        start       = armed0 & (prev_reg == ARC_IDLE) & (st != ARC_IDLE);
        began_next  = start ? now_ms : began_reg;
        timing_next = timing_reg | start;
        elapsed     = now_ms - began_next;
        expire      = armed0 & timing_next & (elapsed >= TIME_W'(hot_start_ms));
        armed_next  = (armed0 & ~expire) | ((st == ARC_IDLE) & ~tig_mode);
    end

    // boost flag is the armed value seen before this tick's update
    always_comb
    begin
        info.state   = st;
        info.boosted = upd ? armed0 : boost_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg  <= 1'b1;
            prev_reg   <= ARC_IDLE;
            began_reg  <= '0;
            timing_reg <= 1'b0;
            boost_reg  <= 1'b0;
        end
        else if (upd)
        begin
            armed_reg  <= armed_next;
            prev_reg   <= st;
            began_reg  <= began_next;
            timing_reg <= timing_next;
            boost_reg  <= armed0;
        end
    end

endmodule

// File: rtl/wcb_dp.sv
// shared multiplier datapath for the boosted current and duty
`timescale 1ns / 1ps

module wcb_dp (
    input  logic                        clk,
    input  wcb_pkg::dp_op_t             op,
    input  logic [wcb_pkg::AMP_W-1:0]   set_current,
    input  wcb_pkg::arc_info_t          info,
    input  logic [wcb_pkg::PCT_W-1:0]   hot_start_percent,
    input  logic [wcb_pkg::PCT_W-1:0]   arc_force_percent,
    input  logic [wcb_pkg::AMP_W-1:0]   duty_full_scale,
    output logic [wcb_pkg::MUL_W-1:0]   acc
);
    import wcb_pkg::*;

    logic [MUL_W-1:0]  acc_reg, acc_next;
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] prod;
    logic [AMP_W-1:0]  hs_gain, af_gain, clamped;

    assign acc = acc_reg;

    // gain factors and clamp of the boosted current
    always_comb
    begin
        hs_gain = PCT_BASE + (info.boosted ? AMP_W'(hot_start_percent) : '0);
        af_gain = PCT_BASE + ((info.state == ARC_STICK) ? AMP_W'(arc_force_percent) : '0);
        if (acc_reg < MUL_W'(AMP_MIN))
            clamped = AMP_MIN;
        else if (acc_reg > MUL_W'(AMP_MAX))
            clamped = AMP_MAX;
        else
            clamped = acc_reg[AMP_W-1:0];
    end

    // operand selection
    always_comb
    begin
        case (op)
            OP_MUL_HS:
            begin
                mul_a = MUL_W'(set_current);
                mul_b = MUL_W'(hs_gain);
            end
            OP_MUL_AF:
            begin
                mul_a = acc_reg;
                mul_b = MUL_W'(af_gain);
            end
            OP_MUL_R10K:
            begin
                mul_a = acc_reg;
                mul_b = RECIP_10K;
            end
            OP_MUL_FS:
            begin
                mul_a = MUL_W'(clamped - AMP_MIN);
                mul_b = MUL_W'(duty_full_scale);
            end
            OP_MUL_R210:
            begin
                mul_a = acc_reg;
                mul_b = RECIP_210;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // accumulator update
    always_comb
    begin
        case (op)
            OP_MUL_HS, OP_MUL_AF, OP_MUL_FS: acc_next = prod[MUL_W-1:0];
            OP_MUL_R10K: acc_next = MUL_W'(prod >> SHIFT_10K);
            OP_MUL_R210: acc_next = MUL_W'(prod >> SHIFT_210);
            default:     acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

endmodule

// File: tb/wcb_pwm_checker.sv
// checker for the weld current boost block: predicts each tick result and compares it
`timescale 1ns / 1ps

module wcb_pwm_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  wcb_pkg::in_item_t              in_data,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  wcb_pkg::out_item_t             out_data,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [wcb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wcb_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             pending
);

    import wcb_pkg::*;

    localparam int MAX_REPORTS = 10;

    // shadow of the control registers
    logic               cfg_tig;
    logic [PCT_W-1:0]   cfg_hs_pct;
    logic [PCT_W-1:0]   cfg_af_pct;
    logic [THR_W-1:0]   cfg_stick;
    logic [THR_W-1:0]   cfg_weld;
    logic [HSMS_W-1:0]  cfg_hs_ms;
    logic [AMP_W-1:0]   cfg_full_scale;

    // controller state
    logic               hs_armed;
    arc_state_t         last_arc;
    logic [TIME_W-1:0]  hs_start;
    logic               hs_timing;
    logic               pwm_run;

    // predicted results still to arrive, oldest first
    out_item_t          pwm_words [$];
    out_item_t          want;

    // work out one tick's result and advance the controller state
    function automatic out_item_t next_pwm_word(input in_item_t tick);
        out_item_t         w;
        arc_state_t        arc;
        logic              boosted;
        int unsigned       amps;
        int unsigned       hs_add;
        int unsigned       af_add;
        logic [TIME_W-1:0] elapsed;
        w = '0;
        if (cfg_tig)
            arc = ARC_IDLE;
        else if (tick.arc_sample < cfg_stick)
            arc = ARC_STICK;
        else if (tick.arc_sample < cfg_weld)
            arc = ARC_WELD;
        else
            arc = ARC_IDLE;
        if (cfg_tig)
            hs_armed = 1'b0;

        // boosted current from the armed flag as it stands now
        boosted = hs_armed;
        hs_add  = boosted ? cfg_hs_pct : 0;
        af_add  = (arc == ARC_STICK) ? cfg_af_pct : 0;
        amps    = tick.set_current * (100 + hs_add) * (100 + af_add) / 10000;

        // hot start timing and expiry, re-armed by an idle arc
        if (hs_armed && last_arc == ARC_IDLE && arc != ARC_IDLE)
        begin
            hs_start  = tick.now_ms;
            hs_timing = 1'b1;
        end
        elapsed = tick.now_ms - hs_start;
        if (hs_armed && hs_timing && elapsed >= cfg_hs_ms)
            hs_armed = 1'b0;
        if (arc == ARC_IDLE && !cfg_tig)
            hs_armed = 1'b1;
        last_arc = arc;

        // overheat stops the pwm, otherwise clamp and scale to a duty
        if (tick.overheat)
            pwm_run = 1'b0;
        else
        begin
            pwm_run = 1'b1;
            if (amps < AMP_MIN)
                amps = AMP_MIN;
            if (amps > AMP_MAX)
                amps = AMP_MAX;
            w.duty = AMP_W'((amps - AMP_MIN) * cfg_full_scale / (AMP_MAX - AMP_MIN));
        end
        w.pwm_on       = pwm_run;
        w.duty_written = !tick.overheat;
        w.arc_state    = arc;
        w.boost_active = boosted;
        return w;
    endfunction

    task automatic note_fail(input string msg);
        if (fail_count < MAX_REPORTS)
            $display("%s", msg);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_tig        = 1'b0;
            cfg_hs_pct     = 7'd25;
            cfg_af_pct     = 7'd20;
            cfg_stick      = 12'd1241;
            cfg_weld       = 12'd2358;
            cfg_hs_ms      = 16'd1000;
            cfg_full_scale = 8'd210;
            hs_armed       = 1'b1;
            last_arc       = ARC_IDLE;
            hs_start       = '0;
            hs_timing      = 1'b0;
            pwm_run        = 1'b1;
            fail_count     = 0;
            pwm_words.delete();
            pending <= 0;
        end
        else
        begin
            // register write transfer
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TIG_MODE:        cfg_tig        = cfg_data[0];
                    CFG_HOT_START_PCT:   cfg_hs_pct     = cfg_data[PCT_W-1:0];
                    CFG_ARC_FORCE_PCT:   cfg_af_pct     = cfg_data[PCT_W-1:0];
                    CFG_STICK_THRESHOLD: cfg_stick      = cfg_data[THR_W-1:0];
                    CFG_WELD_THRESHOLD:  cfg_weld       = cfg_data[THR_W-1:0];
                    CFG_HOT_START_MS:    cfg_hs_ms      = cfg_data[HSMS_W-1:0];
                    CFG_DUTY_FULL_SCALE: cfg_full_scale = cfg_data[AMP_W-1:0];
                    default: ;
                endcase
            end

            // result transfer against the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (pwm_words.size() == 0)
                    note_fail($sformatf("unexpected result: pwm_on %0b duty %0d written %0b arc %0d boost %0b",
                                        out_data.pwm_on, out_data.duty, out_data.duty_written,
                                        out_data.arc_state, out_data.boost_active));
                else
                begin
                    want = pwm_words.pop_front();
                    if (out_data.pwm_on !== want.pwm_on || out_data.duty !== want.duty ||
                        out_data.duty_written !== want.duty_written ||
                        out_data.arc_state !== want.arc_state ||
                        out_data.boost_active !== want.boost_active)
                        note_fail($sformatf({"tick result: expected pwm_on %0b duty %0d written %0b ",
                                             "arc %0d boost %0b, got %0b %0d %0b %0d %0b"},
                                            want.pwm_on, want.duty, want.duty_written,
                                            want.arc_state, want.boost_active,
                                            out_data.pwm_on, out_data.duty, out_data.duty_written,
                                            out_data.arc_state, out_data.boost_active));
                end
            end

            // input transfer
            if (in_valid && !in_stall)
                pwm_words.push_back(next_pwm_word(in_data));
            pending <= pwm_words.size();
        end
    end

endmodule

// File: tb/tb_weld_current_boost_pwm.sv
// testbench top for the weld current boost block: stimulus, stalls, watchdog and verdict
`timescale 1ns / 1ps

module tb_weld_current_boost_pwm;

    import wcb_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 12;
    localparam int CFG_SLOTS    = 1 << CFG_IDX_W;
    // index past the end of the register list
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(CFG_SLOTS - 1);
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    int                    fail_count;
    int                    pending;

    // register values as last written, for choosing samples
    logic [CFG_DATA_W-1:0] regs [0:CFG_SLOTS-1];
    logic [TIME_W-1:0]     clock_ms = '0;
    bit                    idle_en  = 1'b0;
    bit                    stall_en = 1'b0;
    int                    stall_left  = 0;
    int                    quiet_cycles = 0;

    weld_current_boost_pwm dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    wcb_pwm_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_cycles();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 4);
    endfunction

    // a sample that lands in the wanted arc class under the current thresholds
    function automatic logic [SAMPLE_W-1:0] pick_sample(input arc_state_t cls);
        logic [THR_W-1:0] s;
        logic [THR_W-1:0] w;
        s = regs[CFG_STICK_THRESHOLD][THR_W-1:0];
        w = regs[CFG_WELD_THRESHOLD][THR_W-1:0];
        case (cls)
            ARC_STICK: if (s != 0) return SAMPLE_W'($urandom_range(s - 1));
            ARC_WELD:  if (w > s) return SAMPLE_W'($urandom_range(w - 1, s));
            default:   return SAMPLE_W'($urandom_range(SAMPLE_MAX, (s > w) ? s : w));
        endcase
        return SAMPLE_W'($urandom_range(SAMPLE_MAX));
    endfunction

    // one tick transfer, after an optional gap
    task automatic send_tick(input logic [TIME_W-1:0] now, input logic [SAMPLE_W-1:0] sample,
                             input logic [AMP_W-1:0] amps, input logic hot);
        int       gap;
        in_item_t t;
        gap = idle_en ? gap_cycles() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        t.now_ms      = now;
        t.arc_sample  = sample;
        t.set_current = amps;
        t.overheat    = hot;
        in_valid <= 1'b1;
        in_data  <= t;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // wait for the block to go idle, then write every register slot
    task automatic configure(input logic [CFG_DATA_W-1:0] tig, hs, af, stick, weld, ms, fs);
        regs[CFG_TIG_MODE]        = tig;
        regs[CFG_HOT_START_PCT]   = hs;
        regs[CFG_ARC_FORCE_PCT]   = af;
        regs[CFG_STICK_THRESHOLD] = stick;
        regs[CFG_WELD_THRESHOLD]  = weld;
        regs[CFG_HOT_START_MS]    = ms;
        regs[CFG_DUTY_FULL_SCALE] = fs;
        regs[CFG_SPARE]           = CFG_DATA_W'($urandom);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        for (int i = 0; i < CFG_SLOTS; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= regs[CFG_IDX_W'(i)];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        idle_en  = ($urandom_range(3) != 0);
        stall_en <= ($urandom_range(3) != 0);
    endtask

    // arc episodes: idle, then welding with sticking spells, then idle again
    task automatic run_ticks(input int n);
        int                  r;
        int                  left;
        arc_state_t          episode;
        arc_state_t          cls;
        logic [SAMPLE_W-1:0] sample;
        logic [AMP_W-1:0]    amps;
        logic                hot;
        left    = 0;
        episode = ARC_IDLE;
        for (int k = 0; k < n; k++)
        begin
            // time moves on, mostly a little, sometimes far
            r = $urandom_range(99);
            if (r < 70)
                clock_ms += $urandom_range(50);
            else if (r < 90)
                clock_ms += $urandom_range(600, 50);
            else if (r < 97)
                clock_ms += $urandom_range(3000, 600);
            else
                clock_ms = $urandom;

            if (left == 0)
            begin
                r = $urandom_range(99);
                if (episode == ARC_IDLE)
                    episode = (r < 75) ? ARC_WELD : (r < 90) ? ARC_STICK : ARC_IDLE;
                else
                    episode = (r < 50) ? ARC_IDLE : (r < 85) ? ARC_WELD : ARC_STICK;
                left = $urandom_range(10, 1);
            end
            left--;
            cls = episode;
            if (cls == ARC_WELD && $urandom_range(99) < 15)
                cls = ARC_STICK;
            if ($urandom_range(99) < 10)
                sample = SAMPLE_W'($urandom_range(SAMPLE_MAX));
            else
                sample = pick_sample(cls);

            r = $urandom_range(99);
            if (r < 8)
                amps = '0;
            else if (r < 16)
                amps = '1;
            else
                amps = AMP_W'($urandom_range(255));
            hot = ($urandom_range(99) < 8);
            send_tick(clock_ms, sample, amps, hot);
        end
    endtask

    // receiver stalls in runs, switched off in some phases
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (!stall_en)
            out_stall <= 1'b0;
        else if (stall_left > 0)
            stall_left <= stall_left - 1;
        else
        begin
            out_stall  <= !out_stall;
            stall_left <= gap_cycles();
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("weld_current_boost_pwm: mismatch");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        regs[CFG_TIG_MODE]        = 16'd0;
        regs[CFG_HOT_START_PCT]   = 16'd25;
        regs[CFG_ARC_FORCE_PCT]   = 16'd20;
        regs[CFG_STICK_THRESHOLD] = 16'd1241;
        regs[CFG_WELD_THRESHOLD]  = 16'd2358;
        regs[CFG_HOT_START_MS]    = 16'd1000;
        regs[CFG_DUTY_FULL_SCALE] = 16'd210;
        regs[CFG_SPARE]           = 16'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: threshold edges, clamps, overheat and recovery
        send_tick(32'd0,    12'd4095, 8'd0,   1'b0);
        send_tick(32'd5,    12'd2358, 8'd255, 1'b0);
        send_tick(32'd10,   12'd2357, 8'd100, 1'b0);
        send_tick(32'd20,   12'd1241, 8'd100, 1'b0);
        send_tick(32'd30,   12'd1240, 8'd100, 1'b0);
        send_tick(32'd40,   12'd0,    8'd255, 1'b1);
        send_tick(32'd50,   12'd0,    8'd8,   1'b0);
        // hot start runs out exactly at its duration
        send_tick(32'd1010, 12'd2000, 8'd9,   1'b0);
        send_tick(32'd1011, 12'd2000, 8'd10,  1'b0);
        send_tick(32'd1020, 12'd2000, 8'd220, 1'b1);
        send_tick(32'd1030, 12'd3000, 8'd221, 1'b0);
        // hot start timed across the wrap of the millisecond counter
        send_tick(32'hFFFF_FE00, 12'd1500, 8'd150, 1'b0);
        send_tick(32'hFFFF_FFFF, 12'd1500, 8'd150, 1'b0);
        send_tick(32'h0000_01E8, 12'd1500, 8'd150, 1'b0);
        send_tick(32'h0000_0200, 12'd1000, 8'd200, 1'b0);
        // alternating bit patterns
        send_tick(32'hAAAA_5555, 12'hAAA, 8'hAA, 1'b0);
        send_tick(32'h5555_AAAA, 12'h555, 8'h55, 1'b0);
        send_tick(32'h8000_0000, 12'hFFF, 8'hFF, 1'b1);
        send_tick(32'h8000_0001, 12'hFFF, 8'hFF, 1'b0);
        idle_en = 1'b1;
        stall_en <= 1'b1;
        run_ticks(70);

        // percentages above range, zero hot start time, top full scale
        configure(16'd0, 16'd127, 16'd127, 16'd1500, 16'd3000, 16'd0, 16'd255);
        run_ticks(70);
        // tig mode, all lows, zero full scale
        configure(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0);
        run_ticks(60);
        // stick and weld thresholds both at 4095, longest hot start
        configure(16'd0, 16'd100, 16'd100, 16'd4095, 16'd4095, 16'd65535, 16'd1);
        run_ticks(60);
        // stick threshold above the weld threshold
        configure(16'd0, 16'd50, 16'd0, 16'd3000, 16'd500, 16'd20, 16'd210);
        run_ticks(60);
        // random settings, raw words so the unused upper bits move too
        for (int p = 0; p < 5; p++)
        begin
            configure(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                      CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                      CFG_DATA_W'($urandom),
                      ($urandom_range(1) != 0) ? 16'($urandom_range(40)) : 16'($urandom),
                      CFG_DATA_W'($urandom));
            run_ticks(62);
        end

        // drain and verdict
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("weld_current_boost_pwm: match");
        else
            $display("weld_current_boost_pwm: mismatch");
        $finish;
    end

endmodule
